// ===== rtl/atst_pkg.sv =====
package atst_pkg;

  localparam int TILE_W    = 12;
  localparam int POS_W     = 7;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CORNER_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     MAP_DIM_RST    = 8'd128;

  // tileset is TSET_COLS tiles wide
  localparam int TSET_LOG2 = 4;
  localparam int TSET_COLS = 1 << TSET_LOG2;

  // autotile group inside the tileset
  localparam int GRP_COL_LO = 3;
  localparam int GRP_COL_HI = 5;
  localparam int GRP_ROW_LO = 8;
  localparam int GRP_ROW_HI = 11;

  // texture offsets, modulo 2**TILE_W
  localparam logic [TILE_W-1:0] OFF_ZERO = '0;
  localparam logic [TILE_W-1:0] OFF_UL   = TILE_W'(-TSET_COLS - 1);
  localparam logic [TILE_W-1:0] OFF_UR   = TILE_W'(-TSET_COLS + 1);
  localparam logic [TILE_W-1:0] OFF_DL   = TILE_W'(TSET_COLS - 1);
  localparam logic [TILE_W-1:0] OFF_DR   = TILE_W'(TSET_COLS + 1);
  localparam logic [TILE_W-1:0] OFF_U    = TILE_W'(-TSET_COLS);
  localparam logic [TILE_W-1:0] OFF_D    = TILE_W'(TSET_COLS);
  localparam logic [TILE_W-1:0] OFF_L    = TILE_W'(-1);
  localparam logic [TILE_W-1:0] OFF_R    = TILE_W'(1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic [TILE_W-1:0]   tile;
    logic                applies;
    logic                dl;
    logic                du;
    logic                dr;
    logic                dd;
    logic [CORNER_W-1:0] corners;
  } atst_entry_t;

endpackage

// ===== rtl/atst_in_if.sv =====
interface atst_in_if;
  import atst_pkg::*;

  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] tile_value;
  logic              flush;

  modport source (output valid, output tile_value, output flush, input ready);
  modport sink   (input valid, input tile_value, input flush, output ready);

endinterface

// ===== rtl/atst_out_if.sv =====
interface atst_out_if;
  import atst_pkg::*;

  logic                valid;
  logic                ready;
  logic [POS_W-1:0]    col;
  logic [POS_W-1:0]    row;
  logic                applies;
  logic [TILE_W-1:0]   texture;
  logic                half_present;
  logic [TILE_W-1:0]   half_texture;
  logic                half_horizontal;
  logic [CORNER_W-1:0] corners;

  modport source (
    output valid, output col, output row, output applies, output texture,
    output half_present, output half_texture, output half_horizontal,
    output corners, input ready
  );
  modport sink (
    input valid, input col, input row, input applies, input texture,
    input half_present, input half_texture, input half_horizontal,
    input corners, output ready
  );

endinterface

// ===== rtl/atst_front.sv =====
module atst_front #(
  parameter int MAX_DIM = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [atst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atst_pkg::CFG_W-1:0]     cfg_wdata,
  atst_in_if.sink                       in_ch,
  input  logic                          q_full,
  output logic                          q_push,
  output atst_pkg::atst_entry_t         q_entry
);
  import atst_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PTR_W  = $clog2(MAX_DIM);
  localparam int FILL_W = $clog2(MAX_DIM + 3);

  logic [CFG_W-1:0]  map_w_r, map_h_r;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic              h_one;

  logic [TILE_W-1:0] line1_r [MAX_DIM];
  logic [TILE_W-1:0] line2_r [MAX_DIM];
  logic [PTR_W-1:0]  ptr1_r, ptr2_r, ptr1_nxt, ptr2_nxt;
  logic [TILE_W-1:0] rd1_r, rd2_r, byp_r;

  logic [TILE_W-1:0] x0_r, x1_r, x2_r, y1_r, y2_r, z1_r, z2_r;
  logic [TILE_W-1:0] y0, z0;

  logic [FILL_W-1:0] fill_r, fill_nxt, fill_lim;
  logic [PTR_W-1:0]  col_r, row_r, col_nxt, row_nxt;
  logic              emit, row_last, col_last, in_fire;

  logic              tap_valid_r;
  logic [PTR_W-1:0]  tap_col_r, tap_row_r;
  logic              bl_r, bu_r, br_r, bd_r;

  logic [TSET_LOG2-1:0]        tc;
  logic [TILE_W-TSET_LOG2-1:0] tr;
  logic                        applies;
  logic [CORNER_W-1:0]         corners;

  // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
  always_comb begin
    if (map_w_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(map_w_r) > MAX_DIM) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = DIM_W'(map_w_r);
    end
    if (map_h_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(map_h_r) > MAX_DIM) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = DIM_W'(map_h_r);
    end
  end

  assign h_one       = (h_eff == DIM_W'(1));
  assign in_ch.ready = !tap_valid_r || !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign q_push      = tap_valid_r && !q_full;

  // position and line pointer bookkeeping
  always_comb begin
    fill_lim = FILL_W'(h_eff) + FILL_W'(2);
    emit     = (fill_r >= fill_lim - FILL_W'(1));
    row_last = ((DIM_W'(row_r) + DIM_W'(1)) == h_eff);
    col_last = ((DIM_W'(col_r) + DIM_W'(1)) == w_eff);
    fill_nxt = (fill_r < fill_lim) ? fill_r + FILL_W'(1) : fill_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (emit) begin
      if (row_last) begin
        row_nxt = '0;
        if (col_last) begin
          col_nxt  = '0;
          fill_nxt = '0;
        end else begin
          col_nxt = col_r + PTR_W'(1);
        end
      end else begin
        row_nxt = row_r + PTR_W'(1);
      end
    end
    ptr1_nxt = (DIM_W'(ptr1_r) == h_eff - DIM_W'(1)) ? '0 : ptr1_r + PTR_W'(1);
    if (h_one || (DIM_W'(ptr2_r) == h_eff - DIM_W'(2))) begin
      ptr2_nxt = '0;
    end else begin
      ptr2_nxt = ptr2_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r     <= MAP_DIM_RST;
      map_h_r     <= MAP_DIM_RST;
      fill_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      ptr1_r      <= '0;
      ptr2_r      <= '0;
      tap_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAP_WIDTH:  map_w_r <= cfg_wdata;
          REG_MAP_HEIGHT: map_h_r <= cfg_wdata;
          default: ;
        endcase
        fill_r <= '0;
        col_r  <= '0;
        row_r  <= '0;
        ptr1_r <= '0;
        ptr2_r <= '0;
      end else if (in_fire) begin
        fill_r <= fill_nxt;
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        ptr1_r <= ptr1_nxt;
        ptr2_r <= ptr2_nxt;
      end
      if (in_fire) begin
        tap_valid_r <= emit;
      end else if (q_push) begin
        tap_valid_r <= 1'b0;
      end
    end
  end

  // line memories: delay by h and by h-1 (bypassed when h is 1)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd1_r          <= line1_r[ptr1_r];
      line1_r[ptr1_r] <= in_ch.tile_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd2_r           <= line2_r[ptr2_r];
      line2_r[ptr2_r] <= y0;
    end
  end

  assign y0 = rd1_r;
  assign z0 = h_one ? byp_r : rd2_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x0_r  <= in_ch.tile_value;
      x1_r  <= x0_r;
      x2_r  <= x1_r;
      y1_r  <= y0;
      y2_r  <= y1_r;
      byp_r <= y0;
      z1_r  <= z0;
      z2_r  <= z1_r;
      tap_col_r <= col_r;
      tap_row_r <= row_r;
      bl_r  <= (col_r != '0);
      bu_r  <= (row_r != '0);
      br_r  <= !col_last;
      bd_r  <= !row_last;
    end
  end

  // classify the centre tile against its neighbours
  always_comb begin
    tc      = y1_r[TSET_LOG2-1:0];
    tr      = y1_r[TILE_W-1:TSET_LOG2];
    applies = (32'(tc) inside {[GRP_COL_LO:GRP_COL_HI]}) &&
              (32'(tr) inside {[GRP_ROW_LO:GRP_ROW_HI]});
    corners = '0;
    if (applies) begin
      corners[0] = bl_r && bu_r && (z2_r != y1_r) && (z1_r == y1_r) && (y2_r == y1_r);
      corners[1] = bl_r && bd_r && (z0 != y1_r) && (z1_r == y1_r) && (y0 == y1_r);
      corners[2] = br_r && bu_r && (x2_r != y1_r) && (x1_r == y1_r) && (y2_r == y1_r);
      corners[3] = br_r && bd_r && (x0_r != y1_r) && (x1_r == y1_r) && (y0 == y1_r);
    end
    q_entry.col     = POS_W'(tap_col_r);
    q_entry.row     = POS_W'(tap_row_r);
    q_entry.tile    = y1_r;
    q_entry.applies = applies;
    q_entry.dl      = applies && bl_r && (z1_r != y1_r);
    q_entry.du      = applies && bu_r && (y2_r != y1_r);
    q_entry.dr      = applies && br_r && (x1_r != y1_r);
    q_entry.dd      = applies && bd_r && (y0 != y1_r);
    q_entry.corners = corners;
  end

`ifndef SYNTH
  a_row_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(row_r) < h_eff)
    else $error("row counter beyond map height");
  a_col_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    DIM_W'(col_r) < w_eff)
    else $error("column counter beyond map width");
  a_tap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    tap_valid_r && q_full |=> tap_valid_r && $stable(y1_r))
    else $error("stalled centre tile lost");
`endif

endmodule

// ===== rtl/atst_queue.sv =====
module atst_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  atst_pkg::atst_entry_t push_entry,
  output logic                  full,
  output logic                  valid,
  output atst_pkg::atst_entry_t head,
  input  logic                  pop
);
  import atst_pkg::*;

  atst_entry_t       slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W + 1)'(QDEPTH));
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !valid |-> !pop)
    else $error("pop from empty queue");
  a_count_both: assert property (@(posedge clk) disable iff (!rst_n)
    push && pop |=> count_r == $past(count_r))
    else $error("queue count moved on push and pop");
`endif

endmodule

// ===== rtl/atst_back.sv =====
module atst_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  atst_pkg::atst_entry_t q_head,
  output logic                  q_pop,
  atst_out_if.source            out_ch
);
  import atst_pkg::*;

  logic              out_valid_r;
  logic [TILE_W-1:0] tex_off, half_off;
  logic              hp, hh;

  logic [POS_W-1:0]    col_r, row_r;
  logic                applies_r, hp_r, hh_r;
  logic [TILE_W-1:0]   tex_r, half_r;
  logic [CORNER_W-1:0] corners_r;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  // rule priority chain
  always_comb begin
    tex_off  = OFF_ZERO;
    half_off = OFF_ZERO;
    hp       = 1'b0;
    hh       = 1'b0;
    if (q_head.dl && q_head.du && q_head.dr) begin
      tex_off = OFF_UL; half_off = OFF_UR; hp = 1'b1; hh = 1'b1;
    end else if (q_head.dl && q_head.du && q_head.dd) begin
      tex_off = OFF_UL; half_off = OFF_DL; hp = 1'b1;
    end else if (q_head.dl && q_head.dd && q_head.dr) begin
      tex_off = OFF_DL; half_off = OFF_DR; hp = 1'b1; hh = 1'b1;
    end else if (q_head.dr && q_head.du && q_head.dd) begin
      tex_off = OFF_UR; half_off = OFF_DR; hp = 1'b1;
    end else if (q_head.dl && q_head.du) begin
      tex_off = OFF_UL;
    end else if (q_head.dr && q_head.du) begin
      tex_off = OFF_UR;
    end else if (q_head.dr && q_head.dd) begin
      tex_off = OFF_DR;
    end else if (q_head.dl && q_head.dd) begin
      tex_off = OFF_DL;
    end else if (q_head.du && q_head.dd) begin
      tex_off = OFF_U; half_off = OFF_D; hp = 1'b1;
    end else if (q_head.dl && q_head.dr) begin
      tex_off = OFF_L; half_off = OFF_R; hp = 1'b1; hh = 1'b1;
    end else if (q_head.du) begin
      tex_off = OFF_U;
    end else if (q_head.dl) begin
      tex_off = OFF_L;
    end else if (q_head.dr) begin
      tex_off = OFF_R;
    end else if (q_head.dd) begin
      tex_off = OFF_D;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      col_r     <= q_head.col;
      row_r     <= q_head.row;
      applies_r <= q_head.applies;
      tex_r     <= q_head.tile + tex_off;
      hp_r      <= hp;
      half_r    <= hp ? (q_head.tile + half_off) : '0;
      hh_r      <= hh;
      corners_r <= q_head.corners;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.col             = col_r;
  assign out_ch.row             = row_r;
  assign out_ch.applies         = applies_r;
  assign out_ch.texture         = tex_r;
  assign out_ch.half_present    = hp_r;
  assign out_ch.half_texture    = half_r;
  assign out_ch.half_horizontal = hh_r;
  assign out_ch.corners         = corners_r;

endmodule

// ===== rtl/tilemap_autotile_stencil_core.sv =====
// Autotiling stencil for a tile map streamed column by column (x outer, y inner),
// one tile per item. The block sustains one item per clock on both sides
// unless the output stalls. The result for the tile at (col,row) leaves once the
// tile below-right of it has been taken, map_height+1 items later, via the
// window registers, the result queue and the output register; after the last
// map tile send map_height+1 padding items to drain the remaining results.
// The 3x3 neighbourhood comes from two line memories of MAX_DIM entries each
// (one write and one read per item) and three-tap shift registers. Writing
// map_width or map_height restarts the map; dimensions of 0 act as 1 and values
// above MAX_DIM act as MAX_DIM.
module tilemap_autotile_stencil_core #(
  parameter int MAX_DIM = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [atst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atst_pkg::CFG_W-1:0]     cfg_wdata,
  atst_in_if.sink                       in_ch,
  atst_out_if.source                    out_ch
);
  import atst_pkg::*;

  logic        q_push, q_full, q_valid, q_pop;
  atst_entry_t q_entry, q_head;

  atst_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  atst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  atst_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== sim/tilemap_autotile_stencil_core_tb.sv =====
module tilemap_autotile_stencil_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atst_pkg::*;

  localparam int MAX_DIM   = 128;
  localparam int WIN_DEPTH = 2 * MAX_DIM + 3;
  localparam int TS        = TSET_COLS;

  typedef struct {
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic                applies;
    logic [TILE_W-1:0]   texture;
    logic                half_present;
    logic [TILE_W-1:0]   half_texture;
    logic                half_horizontal;
    logic [CORNER_W-1:0] corners;
  } autotile_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  atst_in_if in_ch ();
  atst_out_if out_ch ();

  tilemap_autotile_stencil_core #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // mirror of the block state
  logic [TILE_W-1:0] tile_window [0:WIN_DEPTH-1];
  logic [CFG_W-1:0] map_w_reg;
  logic [CFG_W-1:0] map_h_reg;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned items_seen;

  autotile_t pending_autotiles [$];
  int mismatches = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int unsigned tiles_accepted = 0;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic void restart_map();
    col_pos = 0;
    row_pos = 0;
    items_seen = 0;
  endfunction

  function automatic void autotile_step(input logic [TILE_W-1:0] v);
    int unsigned w, h;
    logic [TILE_W-1:0] t, vl, vu, vr, vd, tex, half;
    logic [CORNER_W-1:0] crn;
    bit bl, bu, br, bd, dl, du, dr, dd, hp, hh, grp;
    autotile_t res;
    w = clamp_dim(map_w_reg);
    h = clamp_dim(map_h_reg);
    for (int k = WIN_DEPTH - 1; k > 0; k--) tile_window[k] = tile_window[k-1];
    tile_window[0] = v;
    items_seen++;
    if (items_seen < h + 2) return;
    t = tile_window[h+1];
    tex = t;
    half = '0;
    crn = '0;
    hp = 1'b0;
    hh = 1'b0;
    grp = (t % TS >= GRP_COL_LO) && (t % TS <= GRP_COL_HI) &&
          (t / TS >= GRP_ROW_LO) && (t / TS <= GRP_ROW_HI);
    if (grp) begin
      vl = tile_window[2*h+1];
      vu = tile_window[h+2];
      vr = tile_window[1];
      vd = tile_window[h];
      bl = col_pos > 0;
      bu = row_pos > 0;
      br = col_pos + 1 < w;
      bd = row_pos + 1 < h;
      dl = bl && vl != t;
      du = bu && vu != t;
      dr = br && vr != t;
      dd = bd && vd != t;
      if (bl && bu && tile_window[2*h+2] != t && vl == t && vu == t) crn[0] = 1'b1;
      if (bl && bd && tile_window[2*h] != t && vl == t && vd == t) crn[1] = 1'b1;
      if (br && bu && tile_window[2] != t && vr == t && vu == t) crn[2] = 1'b1;
      if (br && bd && tile_window[0] != t && vr == t && vd == t) crn[3] = 1'b1;
      if (dl && du && dr) begin
        tex = t - TS - 1; half = t - TS + 1; hp = 1'b1; hh = 1'b1;
      end else if (dl && du && dd) begin
        tex = t - TS - 1; half = t + TS - 1; hp = 1'b1;
      end else if (dl && dd && dr) begin
        tex = t + TS - 1; half = t + TS + 1; hp = 1'b1; hh = 1'b1;
      end else if (dr && du && dd) begin
        tex = t - TS + 1; half = t + TS + 1; hp = 1'b1;
      end else if (dl && du) begin
        tex = t - TS - 1;
      end else if (dr && du) begin
        tex = t - TS + 1;
      end else if (dr && dd) begin
        tex = t + TS + 1;
      end else if (dl && dd) begin
        tex = t + TS - 1;
      end else if (du && dd) begin
        tex = t - TS; half = t + TS; hp = 1'b1;
      end else if (dl && dr) begin
        tex = t - 1; half = t + 1; hp = 1'b1; hh = 1'b1;
      end else if (du) begin
        tex = t - TS;
      end else if (dl) begin
        tex = t - 1;
      end else if (dr) begin
        tex = t + 1;
      end else if (dd) begin
        tex = t + TS;
      end
    end
    res.col = POS_W'(col_pos);
    res.row = POS_W'(row_pos);
    res.applies = grp;
    res.texture = tex;
    res.half_present = hp;
    res.half_texture = hp ? half : '0;
    res.half_horizontal = hp && hh;
    res.corners = crn;
    pending_autotiles.insert(pending_autotiles.size(), res);
    row_pos++;
    if (row_pos >= h) begin
      row_pos = 0;
      col_pos++;
      if (col_pos >= w) restart_map();
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got, input autotile_t ctx);
    if (want != got) begin
      mismatches++;
      $display("%0t: tile (%0d,%0d) %s expected %0h actual %0h",
               $time, ctx.col, ctx.row, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    autotile_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_autotiles.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item expected none actual col %0d row %0d tex %0h",
                 $time, out_ch.col, out_ch.row, out_ch.texture);
      end else begin
        want = pending_autotiles.pop_front();
        check_field("col", want.col, out_ch.col, want);
        check_field("row", want.row, out_ch.row, want);
        check_field("applies", want.applies, out_ch.applies, want);
        check_field("texture", want.texture, out_ch.texture, want);
        check_field("half_present", want.half_present, out_ch.half_present, want);
        check_field("half_texture", want.half_texture, out_ch.half_texture, want);
        check_field("half_horizontal", want.half_horizontal, out_ch.half_horizontal, want);
        check_field("corners", want.corners, out_ch.corners, want);
      end
    end
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

  task automatic send_tile(input logic [TILE_W-1:0] v, input logic f);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tile_value <= v;
    in_ch.flush <= f;
    do @(posedge clk); while (!in_ch.ready);
    autotile_step(v);
    tiles_accepted++;
  endtask

  task automatic wait_for_autotiles();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_autotiles.size() != 0) @(posedge clk);
    // let the window, queue and output register settle
    repeat (8) @(posedge clk);
  endtask

  task automatic set_map_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    map_w_reg = w;
    restart_map();
    cfg_index <= REG_MAP_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    map_h_reg = h;
    restart_map();
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_map(input int unsigned w, input int unsigned h, input bit cut);
    int unsigned n_tiles, r;
    logic [TILE_W-1:0] q, q2, v;
    q = TILE_W'(TS * $urandom_range(GRP_ROW_LO, GRP_ROW_HI) +
                $urandom_range(GRP_COL_LO, GRP_COL_HI));
    q2 = TILE_W'(TS * $urandom_range(GRP_ROW_LO, GRP_ROW_HI) +
                 $urandom_range(GRP_COL_LO, GRP_COL_HI));
    n_tiles = cut ? $urandom_range(0, w * h - 1) : w * h;
    for (int k = 0; k < n_tiles; k++) begin
      r = $urandom_range(99);
      if (r < 55) v = q;
      else if (r < 75) v = q2;
      else if (r < 85) v = q + TILE_W'($urandom_range(0, 34)) - TILE_W'(17);
      else v = TILE_W'($urandom);
      send_tile(v, $urandom_range(19) == 0);
    end
    // padding drains the last column
    if (!cut)
      for (int k = 0; k <= h; k++) send_tile(TILE_W'($urandom), $urandom_range(9) != 0);
  endtask

  task automatic test_reset_dims();
    // 128x128 after reset, only the first column start is reached
    for (int k = 0; k < 131; k++)
      send_tile($urandom_range(1) ? TILE_W'(148) : TILE_W'(164), 1'b0);
    wait_for_autotiles();
  endtask

  task automatic test_neighbour_rules();
    logic [TILE_W-1:0] tiles [0:17];
    tiles = '{12'd148, 12'd148, 12'd0, 12'd148, 12'd148, 12'd4095,
              12'd147, 12'd148, 12'd148,
              12'd0, 12'd4095, 12'd0, 12'd130, 12'd131, 12'd132,
              12'd0, 12'd180, 12'd181};
    set_map_dims(8'd3, 8'd3);
    for (int m = 0; m < 2; m++) begin
      for (int k = 0; k < 9; k++) send_tile(tiles[9*m+k], 1'b0);
      for (int k = 0; k < 4; k++) send_tile(TILE_W'(0), 1'b1);
    end
    wait_for_autotiles();
  endtask

  task automatic test_single_tile_map();
    logic [TILE_W-1:0] tiles [0:2];
    tiles = '{12'd164, 12'd4095, 12'd0};
    set_map_dims(8'd1, 8'd1);
    for (int m = 0; m < 3; m++) begin
      send_tile(tiles[m], 1'b0);
      send_tile(TILE_W'(4095), 1'b1);
      send_tile(TILE_W'(0), 1'b1);
    end
    wait_for_autotiles();
  endtask

  task automatic test_dim_clamping();
    set_map_dims(8'd0, 8'd0);
    send_random_map(1, 1, 1'b0);
    send_random_map(1, 1, 1'b0);
    wait_for_autotiles();
    set_map_dims(8'd200, 8'd1);
    send_random_map(128, 1, 1'b0);
    wait_for_autotiles();
    set_map_dims(8'd0, 8'd255);
    send_random_map(1, 128, 1'b0);
    wait_for_autotiles();
  endtask

  task automatic test_random_maps(input int idle_pct, input int stall_pct, input int quota);
    int unsigned start, r, maps;
    logic [CFG_W-1:0] w_raw, h_raw;
    bit cut;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    start = tiles_accepted;
    while (tiles_accepted - start < quota) begin
      r = $urandom_range(19);
      if (r == 0) begin
        w_raw = CFG_W'($urandom_range(128, 255));
        h_raw = CFG_W'($urandom_range(0, 3));
      end else if (r == 1) begin
        w_raw = CFG_W'($urandom_range(0, 2));
        h_raw = CFG_W'($urandom_range(128, 255));
      end else if (r == 2) begin
        w_raw = '0;
        h_raw = CFG_W'($urandom_range(0, 8));
      end else begin
        w_raw = CFG_W'($urandom_range(1, 8));
        h_raw = CFG_W'($urandom_range(1, 8));
      end
      wait_for_autotiles();
      set_map_dims(w_raw, h_raw);
      maps = $urandom_range(1, 3);
      for (int m = 0; m < maps; m++) begin
        cut = ($urandom_range(9) == 0);
        send_random_map(clamp_dim(w_raw), clamp_dim(h_raw), cut);
        // a cut map is only ended by the next register write
        if (cut) break;
      end
    end
    wait_for_autotiles();
  endtask

  initial begin
    for (int k = 0; k < WIN_DEPTH; k++) tile_window[k] = '0;
    map_w_reg = MAP_DIM_RST;
    map_h_reg = MAP_DIM_RST;
    restart_map();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MAP_WIDTH;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.tile_value <= '0;
    in_ch.flush <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_dims();
    test_neighbour_rules();
    test_single_tile_map();
    test_dim_clamping();
    test_random_maps(0, 0, 150);
    test_random_maps(62, 0, 150);
    test_random_maps(0, 62, 150);
    test_random_maps(15, 15, 150);

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_autotiles.size() == 0) begin
      $display("tilemap_autotile_stencil_core regression: pass");
    end else begin
      $display("tilemap_autotile_stencil_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tilemap_autotile_stencil_core regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/atst_pkg.sv
rtl/atst_in_if.sv
rtl/atst_out_if.sv
rtl/atst_front.sv
rtl/atst_queue.sv
rtl/atst_back.sv
rtl/tilemap_autotile_stencil_core.sv
sim/tilemap_autotile_stencil_core_tb.sv
